### hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Header layout, channel payloads, memory request bundle and action codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES_DEF = 65536;
	localparam int HDR_BYTES      = 8;
	localparam int ALIGN_LOG2     = 2;
	localparam int ALIGN_BYTES    = 1 << ALIGN_LOG2;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic REG_HEAP_SIZE = 1'b0;
	localparam logic REG_MIN_CHUNK = 1'b1;

	typedef struct packed {
		logic [15:0] next;
		logic [15:0] prev;
		logic        used;
	} hdr_t;

	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [15:0] addr;
		hdr_t        wdata;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] request_size;
		logic [15:0] block_address;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] result_address;
		logic [15:0] payload_size;
		logic [16:0] free_bytes;
	} out_t;

endpackage
`default_nettype wire

### hw/rtl/ffha_hdr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_hdr_mem: chunk header store
// Single-port synchronous RAM, one entry per aligned byte offset, with a
// registered read. Offsets beyond the heap read as zero and drop writes.
// ----------------------------------------------------------------------------
module ffha_hdr_mem import ffha_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire mem_req_t req,
	output hdr_t          rdata
);

	localparam int DEPTH = HEAP_BYTES / ALIGN_BYTES;
	localparam int IDX_W = $clog2(DEPTH);

	hdr_t             mem [DEPTH];
	hdr_t             rdata_q;
	logic             zero_q;
	logic [IDX_W-1:0] idx;
	logic             in_store;

	assign idx      = req.addr[ALIGN_LOG2 +: IDX_W];
	assign in_store = {1'b0, req.addr} < 17'(HEAP_BYTES);

	always_ff @(posedge clk) begin
		if (req.wr && in_store) begin
			mem[idx] <= req.wdata;
		end
		if (req.rd) begin
			zero_q <= !in_store;
			if (in_store) begin
				rdata_q <= mem[idx];
			end
		end
	end

	assign rdata = zero_q ? '0 : rdata_q;

endmodule
`default_nettype wire

### hw/rtl/ffha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl: allocator sequencer
// Holds the heap registers, formats the heap and steps allocate, free and query
// through read-modify-write cycles on the header store.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_item,
	output logic             res_valid,
	input  wire logic        res_ready,
	output out_t             res,
	output mem_req_t         mreq,
	input  wire hdr_t        mrdata
);

	typedef enum logic [31:0] {
		ST_IDLE   = 32'h0000_0001,
		ST_FMT0   = 32'h0000_0002,
		ST_FMT1   = 32'h0000_0004,
		ST_A_PREP = 32'h0000_0008,
		ST_A_CHK  = 32'h0000_0010,
		ST_A_EVAL = 32'h0000_0020,
		ST_A_SPL1 = 32'h0000_0040,
		ST_A_SPL2 = 32'h0000_0080,
		ST_A_NXRD = 32'h0000_0100,
		ST_A_NXWR = 32'h0000_0200,
		ST_A_NOSP = 32'h0000_0400,
		ST_S_RD   = 32'h0000_0800,
		ST_S_EV   = 32'h0000_1000,
		ST_F_RD0  = 32'h0000_2000,
		ST_F_W0   = 32'h0000_4000,
		ST_F_RDN  = 32'h0000_8000,
		ST_F_EVN  = 32'h0001_0000,
		ST_F_RDC1 = 32'h0002_0000,
		ST_F_WC1  = 32'h0004_0000,
		ST_F_RDNN = 32'h0008_0000,
		ST_F_WNN  = 32'h0010_0000,
		ST_F_RDC2 = 32'h0020_0000,
		ST_F_EVC  = 32'h0040_0000,
		ST_F_RDP  = 32'h0080_0000,
		ST_F_EVP  = 32'h0100_0000,
		ST_F_RDP2 = 32'h0200_0000,
		ST_F_WP   = 32'h0400_0000,
		ST_F_RDQ  = 32'h0800_0000,
		ST_F_WQ   = 32'h1000_0000,
		ST_Q_RD   = 32'h2000_0000,
		ST_Q_EV   = 32'h4000_0000,
		ST_DONE   = 32'h8000_0000
	} state_t;

	localparam logic [16:0] AMASK = 17'(ALIGN_BYTES - 1);

	state_t      state_q;
	logic        enabled_q;
	logic [15:0] end_q;
	logic [15:0] walk_q;
	logic [15:0] ff_q;
	logic [16:0] cnt_q;
	logic [16:0] min_q;
	logic        ok_q;
	logic [15:0] raddr_q;
	logic [15:0] psize_q;
	logic [15:0] ptr_q;
	logic [16:0] size_q;
	logic [17:0] need_q;
	logic [17:0] split_q;
	logic [15:0] room_q;
	logic [15:0] nx_q;
	logic [15:0] pv_q;
	logic [15:0] p2_q;
	logic [15:0] c_q;
	logic [15:0] nn_q;
	logic [15:0] addr_q;

	logic [16:0] hs_clamp;
	logic [16:0] hs;
	logic [16:0] req_al;
	logic [16:0] min_al;
	logic [15:0] room;
	logic        scan_ff;

	function automatic logic [16:0] cnt_sub(input logic [16:0] c, input logic [17:0] v);
		logic [17:0] d;
		d = {1'b0, c} - v;
		return (v > {1'b0, c}) ? 17'd0 : d[16:0];
	endfunction

	function automatic logic [16:0] cnt_add(input logic [16:0] c, input logic [15:0] v);
		logic [17:0] s;
		s = {1'b0, c} + {2'b0, v};
		return s[17] ? 17'h1FFFF : s[16:0];
	endfunction

	assign hs_clamp = (cfg_data > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : cfg_data;
	assign hs       = hs_clamp & ~AMASK;
	assign min_al   = ({1'b0, cfg_data[15:0]} + AMASK) & ~AMASK;
	assign req_al   = ({1'b0, in_item.request_size} + AMASK) & ~AMASK;
	assign room     = mrdata.next - ptr_q;
	assign scan_ff  = (ptr_q == ff_q);

	// hold input off while a register write takes the idle cycle
	assign in_ready  = (state_q == ST_IDLE) && !cfg_we;
	assign res_valid = (state_q == ST_DONE);
	assign res       = '{ok: ok_q, result_address: raddr_q, payload_size: psize_q,
		free_bytes: cnt_q};

	always_comb begin
		mreq = '0;
		case (state_q)
			ST_FMT0: begin
				mreq.wr    = 1'b1;
				mreq.addr  = '0;
				mreq.wdata = '{next: end_q, prev: 16'd0, used: 1'b0};
			end
			ST_FMT1: begin
				mreq.wr    = 1'b1;
				mreq.addr  = end_q;
				mreq.wdata = '{next: end_q, prev: end_q, used: 1'b1};
			end
			ST_A_CHK, ST_S_RD: begin
				mreq.rd   = 1'b1;
				mreq.addr = ptr_q;
			end
			ST_A_SPL1: begin
				mreq.wr    = 1'b1;
				mreq.addr  = p2_q;
				mreq.wdata = '{next: nx_q, prev: ptr_q, used: 1'b0};
			end
			ST_A_SPL2: begin
				mreq.wr    = 1'b1;
				mreq.addr  = ptr_q;
				mreq.wdata = '{next: p2_q, prev: pv_q, used: 1'b1};
			end
			ST_A_NXRD, ST_F_RDN: begin
				mreq.rd   = 1'b1;
				mreq.addr = nx_q;
			end
			ST_A_NXWR: begin
				mreq.wr    = 1'b1;
				mreq.addr  = nx_q;
				mreq.wdata = '{next: mrdata.next, prev: p2_q, used: mrdata.used};
			end
			ST_A_NOSP: begin
				mreq.wr    = 1'b1;
				mreq.addr  = ptr_q;
				mreq.wdata = '{next: nx_q, prev: pv_q, used: 1'b1};
			end
			ST_F_RD0, ST_F_RDC1, ST_F_RDC2, ST_Q_RD: begin
				mreq.rd   = 1'b1;
				mreq.addr = c_q;
			end
			ST_F_W0: begin
				mreq.wr    = 1'b1;
				mreq.addr  = c_q;
				mreq.wdata = '{next: mrdata.next, prev: mrdata.prev, used: 1'b0};
			end
			ST_F_WC1: begin
				mreq.wr    = 1'b1;
				mreq.addr  = c_q;
				mreq.wdata = '{next: nn_q, prev: mrdata.prev, used: mrdata.used};
			end
			ST_F_RDNN, ST_F_RDQ: begin
				mreq.rd   = 1'b1;
				mreq.addr = nn_q;
			end
			ST_F_WNN: begin
				mreq.wr    = 1'b1;
				mreq.addr  = nn_q;
				mreq.wdata = '{next: mrdata.next, prev: c_q, used: mrdata.used};
			end
			ST_F_RDP, ST_F_RDP2: begin
				mreq.rd   = 1'b1;
				mreq.addr = pv_q;
			end
			ST_F_WP: begin
				mreq.wr    = 1'b1;
				mreq.addr  = pv_q;
				mreq.wdata = '{next: nn_q, prev: mrdata.prev, used: mrdata.used};
			end
			ST_F_WQ: begin
				mreq.wr    = 1'b1;
				mreq.addr  = nn_q;
				mreq.wdata = '{next: mrdata.next, prev: pv_q, used: mrdata.used};
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enabled_q <= 1'b0;
			end_q     <= '0;
			walk_q    <= '0;
			ff_q      <= '0;
			cnt_q     <= '0;
			min_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_we && cfg_index == REG_HEAP_SIZE) begin
						ff_q <= '0;
						if (hs <= 17'(2 * HDR_BYTES)) begin
							enabled_q <= 1'b0;
							cnt_q     <= '0;
						end else begin
							enabled_q <= 1'b1;
							end_q     <= 16'(hs - 17'(HDR_BYTES));
							walk_q    <= 16'(hs - 17'(2 * HDR_BYTES));
							cnt_q     <= hs - 17'(HDR_BYTES);
							state_q   <= ST_FMT0;
						end
					end else if (cfg_we && cfg_index == REG_MIN_CHUNK) begin
						min_q <= min_al;
					end else if (in_valid) begin
						ok_q    <= 1'b1;
						raddr_q <= '0;
						psize_q <= '0;
						addr_q  <= in_item.block_address;
						c_q     <= in_item.block_address - 16'(HDR_BYTES);
						ptr_q   <= ff_q;
						size_q  <= (req_al < min_q) ? min_q : req_al;
						case (in_item.action)
							ACT_ALLOC: begin
								ok_q    <= 1'b0;
								state_q <= enabled_q ? ST_A_PREP : ST_DONE;
							end
							ACT_FREE: begin
								if (!enabled_q || in_item.block_address < 16'(HDR_BYTES)
									|| in_item.block_address > end_q) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_F_RD0;
								end
							end
							ACT_QUERY: begin
								if (!enabled_q || in_item.block_address < 16'(HDR_BYTES)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_Q_RD;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_FMT0: state_q <= ST_FMT1;
				ST_FMT1: state_q <= ST_IDLE;
				ST_A_PREP: begin
					need_q  <= {1'b0, size_q} + 18'(HDR_BYTES);
					split_q <= {1'b0, size_q} + {1'b0, min_q} + 18'(2 * HDR_BYTES);
					state_q <= ST_A_CHK;
				end
				ST_A_CHK: begin
					state_q <= (ptr_q < walk_q) ? ST_A_EVAL : ST_DONE;
				end
				ST_A_EVAL: begin
					if (mrdata.next <= ptr_q) begin
						state_q <= ST_DONE;
					end else if (mrdata.used || {2'b0, room} < need_q) begin
						ptr_q   <= mrdata.next;
						state_q <= ST_A_CHK;
					end else begin
						ok_q    <= 1'b1;
						raddr_q <= ptr_q + 16'(HDR_BYTES);
						nx_q    <= mrdata.next;
						pv_q    <= mrdata.prev;
						room_q  <= room;
						p2_q    <= ptr_q + need_q[15:0];
						state_q <= ({2'b0, room} >= split_q) ? ST_A_SPL1 : ST_A_NOSP;
					end
				end
				ST_A_SPL1: state_q <= ST_A_SPL2;
				ST_A_SPL2: begin
					cnt_q <= cnt_sub(cnt_q, need_q);
					if (nx_q != end_q) begin
						state_q <= ST_A_NXRD;
					end else begin
						state_q <= scan_ff ? ST_S_RD : ST_DONE;
					end
				end
				ST_A_NXRD: state_q <= ST_A_NXWR;
				ST_A_NXWR: state_q <= scan_ff ? ST_S_RD : ST_DONE;
				ST_A_NOSP: begin
					cnt_q   <= cnt_sub(cnt_q, {2'b0, room_q});
					state_q <= scan_ff ? ST_S_RD : ST_DONE;
				end
				ST_S_RD: state_q <= ST_S_EV;
				ST_S_EV: begin
					// advance past used chunks to the new lowest free one
					if (mrdata.used && ptr_q != end_q) begin
						ptr_q   <= (mrdata.next > ptr_q) ? mrdata.next : end_q;
						state_q <= ST_S_RD;
					end else begin
						ff_q    <= ptr_q;
						state_q <= ST_DONE;
					end
				end
				ST_F_RD0: state_q <= ST_F_W0;
				ST_F_W0: begin
					nx_q <= mrdata.next;
					if (c_q < ff_q) begin
						ff_q <= c_q;
					end
					if (mrdata.next >= c_q) begin
						cnt_q <= cnt_add(cnt_q, mrdata.next - c_q);
					end else begin
						cnt_q <= cnt_sub(cnt_q, {2'b0, c_q - mrdata.next});
					end
					if (mrdata.next != c_q && mrdata.next != end_q) begin
						state_q <= ST_F_RDN;
					end else begin
						state_q <= ST_F_RDC2;
					end
				end
				ST_F_RDN: state_q <= ST_F_EVN;
				ST_F_EVN: begin
					if (!mrdata.used) begin
						if (ff_q == nx_q) begin
							ff_q <= c_q;
						end
						nn_q    <= mrdata.next;
						state_q <= ST_F_RDC1;
					end else begin
						state_q <= ST_F_RDC2;
					end
				end
				ST_F_RDC1: state_q <= ST_F_WC1;
				ST_F_WC1:  state_q <= ST_F_RDNN;
				ST_F_RDNN: state_q <= ST_F_WNN;
				ST_F_WNN:  state_q <= ST_F_RDC2;
				ST_F_RDC2: state_q <= ST_F_EVC;
				ST_F_EVC: begin
					pv_q    <= mrdata.prev;
					nn_q    <= mrdata.next;
					state_q <= (mrdata.prev != c_q) ? ST_F_RDP : ST_DONE;
				end
				ST_F_RDP: state_q <= ST_F_EVP;
				ST_F_EVP: begin
					if (!mrdata.used) begin
						if (ff_q == c_q) begin
							ff_q <= pv_q;
						end
						state_q <= ST_F_RDP2;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_F_RDP2: state_q <= ST_F_WP;
				ST_F_WP:   state_q <= ST_F_RDQ;
				ST_F_RDQ:  state_q <= ST_F_WQ;
				ST_F_WQ:   state_q <= ST_DONE;
				ST_Q_RD:   state_q <= ST_Q_EV;
				ST_Q_EV: begin
					psize_q <= (mrdata.next > addr_q) ? mrdata.next - addr_q : 16'd0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap with boundary-tag chunk headers
// Use: write heap_size on the cfg port to format the heap (header writes follow,
// input held off meanwhile), optionally min_chunk_size.
// Items enter on in_valid/in_ready: allocate, free or payload size query.
// Each item gives one result transfer on out_valid/out_ready with the free
// byte count after the action.
// One item at a time. Allocate prepares its sizes, walks the chunk headers from
// the lowest-free pointer, writes the split headers or marks the chunk used, and
// moves that pointer past used headers when the chunk was the lowest free one.
// Free marks the chunk free and merges free next and previous neighbours; query
// reads one header; ignored items and unused actions go straight to the result.
// A header visit is a read of the single-port header RAM, then an evaluate state.
// Reset: heap disabled, counters zero; header RAM content is undefined until
// formatted. A stalled receiver holds the result in the output register; the
// next item is still taken and worked, and waits only to hand over its result.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_item
);

	mem_req_t mreq;
	hdr_t     mrdata;
	logic     res_valid;
	logic     res_ready;
	out_t     res;
	logic     out_valid_q;
	out_t     out_q;

	ffha_hdr_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (mrdata)
	);

	ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mreq      (mreq),
		.mrdata    (mrdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-fit heap allocator
// Formats the heap at several sizes and minimum chunk sizes, runs directed
// allocate/free/query sequences and random traffic, and compares every result
// transfer with a behavioral heap model kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
	import ffha_pkg::*;

	localparam int unsigned HEAP_MAX    = 65536;
	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned SETTLE      = 60;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [16:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_t         in_item;
	logic        out_valid;
	logic        out_ready;
	out_t        out_item;

	first_fit_heap_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// heap model state
	logic [15:0] hdr_next [0:HEAP_MAX-1];
	logic [15:0] hdr_prev [0:HEAP_MAX-1];
	bit          hdr_used [0:HEAP_MAX-1];
	bit          hdr_written [0:HEAP_MAX-1];
	int unsigned heap_bytes_cfg;
	int unsigned min_chunk;
	int unsigned first_free;
	int unsigned free_count;
	int unsigned end_off;
	int unsigned walk_limit;
	bit          heap_on;

	out_t        pending_replies [$];
	int unsigned granted_blocks [$];
	int unsigned released_blocks [$];
	int unsigned cycles;
	int unsigned mismatches;
	int unsigned n_grants, n_no_fit, n_frees, n_queries, n_other, n_settings;
	bit          quiet;
	int          stall_left;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_replies.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int unsigned align_up(int unsigned x);
		return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	endfunction

	function automatic int unsigned get_next(int unsigned o);
		return o < HEAP_MAX ? int'(hdr_next[o]) : 0;
	endfunction

	function automatic int unsigned get_prev(int unsigned o);
		return o < HEAP_MAX ? int'(hdr_prev[o]) : 0;
	endfunction

	function automatic bit get_used(int unsigned o);
		return o < HEAP_MAX ? hdr_used[o] : 1'b0;
	endfunction

	function automatic void put_next(int unsigned o, int unsigned v);
		if (o < HEAP_MAX) begin
			hdr_next[o] = v[15:0];
			hdr_written[o] = 1'b1;
		end
	endfunction

	function automatic void put_prev(int unsigned o, int unsigned v);
		if (o < HEAP_MAX) begin
			hdr_prev[o] = v[15:0];
			hdr_written[o] = 1'b1;
		end
	endfunction

	function automatic void put_used(int unsigned o, bit v);
		if (o < HEAP_MAX) begin
			hdr_used[o] = v;
			hdr_written[o] = 1'b1;
		end
	endfunction

	function automatic void count_add(int unsigned v);
		free_count = (free_count + v > 32'h1FFFF) ? 32'h1FFFF : free_count + v;
	endfunction

	function automatic void count_sub(int unsigned v);
		free_count = (v > free_count) ? 0 : free_count - v;
	endfunction

	function automatic void format_model();
		int unsigned hs;
		hs = heap_bytes_cfg > HEAP_MAX ? HEAP_MAX : heap_bytes_cfg;
		hs = hs - hs % ALIGN_BYTES;
		first_free = 0;
		if (hs <= 2 * HDR_BYTES) begin
			heap_on = 1'b0;
			walk_limit = 0;
			free_count = 0;
			return;
		end
		heap_on = 1'b1;
		end_off = hs - HDR_BYTES;
		walk_limit = hs - 2 * HDR_BYTES;
		put_next(0, end_off);
		put_prev(0, 0);
		put_used(0, 1'b0);
		put_next(end_off, end_off);
		put_prev(end_off, end_off);
		put_used(end_off, 1'b1);
		free_count = end_off;
	endfunction

	function automatic bit model_alloc(int unsigned req, output int unsigned addr);
		int unsigned size, ptr, nx, room, left, p2, cur, n;
		size = align_up(req);
		ptr = first_free;
		addr = 0;
		if (!heap_on)
			return 1'b0;
		if (size < min_chunk)
			size = min_chunk;
		while (ptr < walk_limit) begin
			nx = get_next(ptr);
			if (nx <= ptr)
				return 1'b0;
			room = nx - ptr;
			if (get_used(ptr) || room < HDR_BYTES + size) begin
				ptr = nx;
				continue;
			end
			left = room - HDR_BYTES - size;
			if (left >= HDR_BYTES + min_chunk) begin
				p2 = ptr + HDR_BYTES + size;
				put_used(p2, 1'b0);
				put_next(p2, nx);
				put_prev(p2, ptr);
				put_next(ptr, p2);
				put_used(ptr, 1'b1);
				if (nx != end_off)
					put_prev(nx, p2);
				count_sub(size + HDR_BYTES);
			end else begin
				put_used(ptr, 1'b1);
				count_sub(room);
			end
			if (ptr == first_free) begin
				cur = first_free;
				while (get_used(cur) && cur != end_off) begin
					n = get_next(cur);
					cur = n > cur ? n : end_off;
				end
				first_free = cur;
			end
			addr = ptr + HDR_BYTES;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void model_free(int unsigned addr);
		int unsigned c, nx, pv;
		if (!heap_on || addr < HDR_BYTES || addr > end_off)
			return;
		c = addr - HDR_BYTES;
		put_used(c, 1'b0);
		if (c < first_free)
			first_free = c;
		nx = get_next(c);
		if (nx >= c)
			count_add(nx - c);
		else
			count_sub(c - nx);
		if (nx != c && !get_used(nx) && nx != end_off) begin
			if (first_free == nx)
				first_free = c;
			put_next(c, get_next(nx));
			put_prev(get_next(nx), c);
		end
		pv = get_prev(c);
		if (pv != c && !get_used(pv)) begin
			if (first_free == c)
				first_free = pv;
			put_next(pv, get_next(c));
			put_prev(get_next(c), pv);
		end
	endfunction

	function automatic int unsigned model_query(int unsigned addr);
		int unsigned nx;
		if (!heap_on || addr < HDR_BYTES)
			return 0;
		nx = get_next(addr - HDR_BYTES);
		return nx > addr ? nx - addr : 0;
	endfunction

	function automatic out_t heap_apply(in_t it);
		out_t        o;
		int unsigned a;
		o = '0;
		o.ok = 1'b1;
		case (it.action)
			ACT_ALLOC: begin
				if (model_alloc(it.request_size, a)) begin
					o.result_address = a[15:0];
					granted_blocks.push_back(a);
					n_grants++;
				end else begin
					o.ok = 1'b0;
					n_no_fit++;
				end
			end
			ACT_FREE: begin
				model_free(it.block_address);
				n_frees++;
			end
			ACT_QUERY: begin
				o.payload_size = 16'(model_query(it.block_address));
				n_queries++;
			end
			default: n_other++;
		endcase
		o.free_bytes = free_count[16:0];
		return o;
	endfunction

	// A header read of a never-written store entry must not be caused.
	function automatic bit reads_unwritten(logic [1:0] act, int unsigned addr);
		if (!heap_on || addr < HDR_BYTES)
			return 1'b0;
		if (act == ACT_FREE && addr > end_off)
			return 1'b0;
		if (act == ACT_FREE || act == ACT_QUERY)
			return !hdr_written[addr - HDR_BYTES];
		return 1'b0;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (quiet || r < 75)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic int unsigned pick_request();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(64);
		if (r < 90)
			return $urandom_range(1024, 65);
		if (r < 97)
			return $urandom_range(8192, 1025);
		return $urandom_range(65535);
	endfunction

	// receiver side: random stalls on the result channel
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!quiet) begin
				case ($urandom_range(99)) inside
					[0:14]:  stall_left = $urandom_range(3, 1);
					[15:17]: stall_left = $urandom_range(50, 10);
					default: stall_left = 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", out_item);
			end else begin
				want = pending_replies.pop_front();
				if (out_item.ok !== want.ok
						|| out_item.result_address !== want.result_address
						|| out_item.payload_size !== want.payload_size
						|| out_item.free_bytes !== want.free_bytes) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected ok=%0d addr=%0d size=%0d free=%0d, got ok=%0d addr=%0d size=%0d free=%0d",
							want.ok, want.result_address, want.payload_size,
							want.free_bytes, out_item.ok, out_item.result_address,
							out_item.payload_size, out_item.free_bytes);
				end
			end
		end
	end

	task automatic send_item(logic [1:0] act, int unsigned req, int unsigned addr);
		in_t         it;
		int unsigned gap;
		it.action = act;
		it.request_size = req[15:0];
		it.block_address = addr[15:0];
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		pending_replies.push_back(heap_apply(it));
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[16:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_HEAP_SIZE) begin
			heap_bytes_cfg = value & 32'h1FFFF;
			format_model();
			granted_blocks.delete();
			released_blocks.delete();
		end else begin
			min_chunk = align_up(value & 32'hFFFF);
		end
		n_settings++;
	endtask

	task automatic free_granted(int unsigned idx);
		int unsigned a;
		a = granted_blocks[idx];
		granted_blocks.delete(idx);
		released_blocks.push_back(a);
		send_item(ACT_FREE, $urandom_range(65535), a);
	endtask

	task automatic test_disabled_heap();
		send_item(ACT_ALLOC, 16, 0);
		send_item(ACT_FREE, 0, 8);
		send_item(ACT_QUERY, 0, 8);
		send_item(2'd3, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_heap_extremes();
		int unsigned a;
		write_reg(REG_HEAP_SIZE, 16);
		write_reg(REG_MIN_CHUNK, 0);
		send_item(ACT_ALLOC, 4, 0);
		write_reg(REG_HEAP_SIZE, 32'h1FFFF);
		send_item(ACT_ALLOC, 0, 0);
		send_item(ACT_ALLOC, 65535, 0);
		send_item(ACT_ALLOC, 1, 0);
		a = granted_blocks[0];
		send_item(ACT_QUERY, 0, a);
		send_item(ACT_QUERY, 0, 4);
		send_item(ACT_FREE, 0, 0);
		send_item(ACT_FREE, 0, 7);
		send_item(ACT_FREE, 0, 65535);
		free_granted(0);
		// release the same block twice
		send_item(ACT_FREE, 0, a);
	endtask

	task automatic test_min_chunk();
		write_reg(REG_MIN_CHUNK, 65535);
		send_item(ACT_ALLOC, 1, 0);
		write_reg(REG_MIN_CHUNK, 13);
		send_item(ACT_ALLOC, 0, 0);
	endtask

	task automatic test_tiny_heap();
		write_reg(REG_HEAP_SIZE, 101);
		write_reg(REG_MIN_CHUNK, 0);
		repeat (4) send_item(ACT_ALLOC, 16, 0);
		free_granted(1);
		free_granted(0);
		free_granted(0);
		send_item(ACT_ALLOC, 40, 0);
	endtask

	task automatic test_random_traffic();
		int unsigned heap_pick [6];
		int unsigned min_pick [6];
		int unsigned r, a, k;
		logic [1:0]  act;
		heap_pick = '{65536, 200, $urandom_range(4000, 17), 32'h1FFFF, 20,
			$urandom_range(65536, 1000)};
		min_pick = '{0, 4, $urandom_range(32), 65535, $urandom_range(200), 1};
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_HEAP_SIZE, heap_pick[p]);
			write_reg(REG_MIN_CHUNK, min_pick[p]);
			quiet = (p == 2);
			for (int i = 0; i < 112; i++) begin
				if (i == 50)
					drain_results();
				r = $urandom_range(99);
				if (r < 45 || (r < 85 && granted_blocks.size() == 0)) begin
					send_item(ACT_ALLOC, pick_request(), $urandom_range(65535));
				end else if (r < 75) begin
					free_granted($urandom_range(granted_blocks.size() - 1));
				end else if (r < 85) begin
					k = $urandom_range(granted_blocks.size() - 1);
					send_item(ACT_QUERY, $urandom_range(65535), granted_blocks[k]);
				end else if (r < 97) begin
					act = r[0] ? ACT_FREE : ACT_QUERY;
					if (r < 90 && released_blocks.size() != 0)
						a = released_blocks[$urandom_range(released_blocks.size() - 1)];
					else
						a = $urandom_range(65535);
					// fall back to an ignored low address when the header is unknown
					if (reads_unwritten(act, a))
						a = $urandom_range(HDR_BYTES - 1);
					send_item(act, $urandom_range(65535), a);
				end else begin
					send_item(2'd3, $urandom_range(65535), $urandom_range(65535));
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEAP_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		cycles = 0;
		mismatches = 0;
		stall_left = 0;
		quiet = 1'b0;
		heap_bytes_cfg = 0;
		min_chunk = 0;
		first_free = 0;
		free_count = 0;
		end_off = 0;
		walk_limit = 0;
		heap_on = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_heap();
		test_heap_extremes();
		test_min_chunk();
		test_tiny_heap();
		test_random_traffic();

		drain_results();
		if (pending_replies.size() != 0)
			mismatches++;
		$display("covered %0d register writes, %0d grants, %0d failed allocations,",
			n_settings, n_grants, n_no_fit);
		$display("%0d frees, %0d size queries and %0d unused action codes",
			n_frees, n_queries, n_other);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_hdr_mem.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator.sv
tb/sv/testbench.sv
